/* hw/rtl/apodization_window_weight_defines.svh */
// Assertion helpers for the apodization window weight block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef APODIZATION_WINDOW_WEIGHT_DEFINES_SVH
`define APODIZATION_WINDOW_WEIGHT_DEFINES_SVH

// Check cons in the same cycle as ant.
`define AWW_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("aww: assertion failed");

// Check cons in the cycle after ant.
`define AWW_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("aww: assertion failed");

`endif

/* hw/rtl/aww_pkg.sv */
`default_nettype none

package aww_pkg;

  localparam int POSITION_W  = 17;
  localparam int WEIGHT_W    = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int WIN_TYPE_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TYPE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAPER_FRACTION = 1'd1;

  localparam logic [WIN_TYPE_W-1:0] WIN_RECT     = 3'd0;
  localparam logic [WIN_TYPE_W-1:0] WIN_HANN     = 3'd1;
  localparam logic [WIN_TYPE_W-1:0] WIN_HAMMING  = 3'd2;
  localparam logic [WIN_TYPE_W-1:0] WIN_BLACKMAN = 3'd3;
  localparam logic [WIN_TYPE_W-1:0] WIN_TUKEY    = 3'd4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 16'd32768;
  localparam logic [WEIGHT_W-1:0] TAPER_RESET  = 16'd16384;

  // Widest cases over the supported table depths.
  localparam int DIVIDEND_W  = 35;
  localparam int DIVISOR_W   = 18;
  localparam int INDEX_W_MAX = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam int COS_W = 32;
  localparam int ACC_W = 40;
  localparam int COEF_W = 8;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Final rounding: floor((v + 100 * 2^14) / (100 * 2^15)).
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 40'sd1638400;
  localparam int FRAC_SHIFT  = 15;
  localparam int QUOT_W      = 23;
  localparam int PROD_W      = 46;
  localparam int RECIP_SHIFT = 29;
  localparam logic [QUOT_W-1:0] RECIP_100 = 23'd5368710;
  localparam int SCALED_W    = PROD_W - RECIP_SHIFT;

  typedef enum logic [2:0] {
    KIND_DIRECT,
    KIND_HANN,
    KIND_HAMMING,
    KIND_BLACKMAN,
    KIND_TAPER
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [WEIGHT_W-1:0]      direct_weight;
    logic [DIVIDEND_W-1:0]    dividend;
    logic [DIVISOR_W-1:0]     divisor;
    logic [INDEX_W_MAX-1:0]   k2;
  } aww_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } aww_queue_status_t;

  // Cosine of binary angle p (2^-32 turn), signed Q30, quadrant folded,
  // 9-term Taylor series with truncated products. Table contents only.
  function automatic logic signed [COS_W-1:0] cos_q30(input logic [31:0] p);
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    q = 64'(p) >> 30;
    r = 64'(p) & 64'h3FFF_FFFF;
    if (q[0]) begin
      r = (64'd1 << 30) - r;
    end
    x    = (r * PI_Q30) >> 31;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (q == 64'd1 || q == 64'd2) begin
      sum = -sum;
    end
    return COS_W'(sum);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/aww_if.sv */
`default_nettype none

interface aww_pos_if import aww_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [POSITION_W-1:0] position;
  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface aww_weight_if import aww_pkg::*;;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  modport source (output valid, output weight, input ready);
  modport sink (input valid, input weight, output ready);
endinterface

interface aww_cfg_if import aww_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/apodization_window_weight.sv */
// Apodization window weight.
// Channels: pos_i takes one aperture position per beat (signed Q2.15),
// weight_o returns one window weight per beat (unsigned Q1.15, 0..1.0),
// in the order positions came in. cfg_i writes window_type (index 0) and
// taper_fraction (index 1); it is always ready and should be written only
// while no beat is in flight.
// Throughput: one beat per cycle, sustained while weight_o is taken.
// Path: from the accepting edge a beat passes the front register, the
// queue, the bit-per-stage phase divider that maps a position onto the
// cosine table index, the registered table read, the coefficient sum,
// the reciprocal rounding multiply and the weight_o output register.
// Reset: window_type goes to rect, taper_fraction to one half, all
// pipeline valids clear. The cosine table is constant; no fill pass.
// Stall: when weight_o is not taken, the back pipeline holds, the two-deep
// queue fills, and only then does pos_i.ready drop.
`default_nettype none
`include "apodization_window_weight_defines.svh"

module apodization_window_weight import aww_pkg::*; #(
  parameter int COSINE_TABLE_DEPTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  aww_cfg_if.sink      cfg_i,
  aww_pos_if.sink      pos_i,
  aww_weight_if.source weight_o
);

  logic              push;
  logic              pop;
  aww_item_t         front_item;
  aww_item_t         head;
  aww_queue_status_t q_status;

  // Front: register config, classify position, build divider operands.
  aww_front #(
    .COSINE_TABLE_DEPTH(COSINE_TABLE_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .pos_i  (pos_i),
    .full_i (q_status.full),
    .push_o (push),
    .item_o (front_item)
  );

  // Decouple: absorb back-end stalls until the queue is full.
  aww_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Back: divide, look up cosines, combine, round and saturate.
  aww_back #(
    .COSINE_TABLE_DEPTH(COSINE_TABLE_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (q_status.empty),
    .pop_o    (pop),
    .weight_o (weight_o)
  );

  // Saturation must hold the weight at or below one.
  `AWW_ASSERT_NOW(a_weight_max, weight_o.valid, weight_o.weight <= WEIGHT_ONE)
  // Queue count stays consistent.
  `AWW_ASSERT_NOW(a_queue_flags, 1'b1, !(q_status.full && q_status.empty))
  // A full queue can drain by at most one beat per cycle.
  `AWW_ASSERT_NEXT(a_queue_drain, q_status.full, !q_status.empty)

endmodule

`default_nettype wire

/* hw/rtl/aww_front.sv */
`default_nettype none

module aww_front import aww_pkg::*; #(
  parameter int COSINE_TABLE_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aww_cfg_if.sink       cfg_i,
  aww_pos_if.sink       pos_i,
  input  logic          full_i,
  output logic          push_o,
  output aww_item_t     item_o
);

  localparam int K2_W = $clog2(2 * COSINE_TABLE_DEPTH + 1);

  logic [WIN_TYPE_W-1:0] win_type_q;
  logic [WEIGHT_W-1:0]   taper_q;
  logic                  fv_q, fv_d;
  aww_item_t             item_q, item_d;

  logic                  accept;
  logic                  in_span;
  logic signed [POSITION_W:0] t_ext;
  logic [POSITION_W-1:0] t16;
  logic [WEIGHT_W-1:0]   alpha;
  logic [POSITION_W-1:0] right_edge;
  logic [POSITION_W-1:0] num;
  logic [POSITION_W-1:0] den;
  logic [35:0]           k2_full;
  logic [K2_W-1:0]       k2_raw, k2_mod;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_type_q <= WIN_RECT;
      taper_q    <= TAPER_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WINDOW_TYPE:    win_type_q <= cfg_i.data[WIN_TYPE_W-1:0];
        REG_TAPER_FRACTION: taper_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign pos_i.ready = !fv_q || !full_i;
  assign accept      = pos_i.valid && pos_i.ready;
  assign push_o      = fv_q && !full_i;
  assign item_o      = item_q;

  assign in_span    = (pos_i.position >= -17'sd32768) && (pos_i.position <= 17'sd32768);
  assign t_ext      = (POSITION_W+1)'(pos_i.position) + 18'sd32768;
  assign t16        = t_ext[POSITION_W-1:0];
  assign alpha      = (taper_q > WEIGHT_ONE) ? WEIGHT_ONE : taper_q;
  assign right_edge = 17'd65536 - POSITION_W'(alpha);

  // Second Blackman harmonic: index of 2t, folded into the table.
  assign k2_full = (36'(t16) * 36'(4 * COSINE_TABLE_DEPTH) + 36'd65536) >> 17;
  assign k2_raw  = k2_full[K2_W-1:0];
  always_comb begin
    if (k2_raw >= K2_W'(2 * COSINE_TABLE_DEPTH)) begin
      k2_mod = k2_raw - K2_W'(2 * COSINE_TABLE_DEPTH);
    end else if (k2_raw >= K2_W'(COSINE_TABLE_DEPTH)) begin
      k2_mod = k2_raw - K2_W'(COSINE_TABLE_DEPTH);
    end else begin
      k2_mod = k2_raw;
    end
  end

  always_comb begin
    item_d               = '0;
    item_d.kind          = KIND_DIRECT;
    item_d.direct_weight = WEIGHT_ONE;
    num                  = t16;
    den                  = 17'd65536;
    unique case (win_type_q)
      WIN_HANN:     item_d.kind = KIND_HANN;
      WIN_HAMMING:  item_d.kind = KIND_HAMMING;
      WIN_BLACKMAN: item_d.kind = KIND_BLACKMAN;
      WIN_TUKEY: begin
        den = {alpha, 1'b0};
        if (alpha == '0) begin
          item_d.kind = KIND_DIRECT;
        end else if (t16 < POSITION_W'(alpha)) begin
          item_d.kind = KIND_TAPER;
        end else if (t16 > right_edge) begin
          item_d.kind = KIND_TAPER;
          num         = 17'd65536 - t16;
        end
      end
      default: item_d.kind = KIND_DIRECT;
    endcase
    if (!in_span) begin
      item_d.kind          = KIND_DIRECT;
      item_d.direct_weight = '0;
    end
    if (item_d.kind == KIND_DIRECT) begin
      item_d.dividend = '0;
      item_d.divisor  = DIVISOR_W'(1);
    end else begin
      // k = floor((num * 2D + den) / (2 den))
      item_d.dividend = DIVIDEND_W'(num) * DIVIDEND_W'(2 * COSINE_TABLE_DEPTH)
                      + DIVIDEND_W'(den);
      item_d.divisor  = {den, 1'b0};
    end
    item_d.k2 = INDEX_W_MAX'(k2_mod);
  end

  always_comb begin
    if (accept) begin
      fv_d = 1'b1;
    end else if (push_o) begin
      fv_d = 1'b0;
    end else begin
      fv_d = fv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/aww_queue.sv */
`default_nettype none

module aww_queue import aww_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  aww_item_t         item_i,
  input  logic              pop_i,
  output aww_item_t         head_o,
  output aww_queue_status_t status_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  aww_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/aww_cos_rom.sv */
`default_nettype none

module aww_cos_rom import aww_pkg::*; #(
  parameter int COSINE_TABLE_DEPTH = 1024,
  localparam int IW = $clog2(COSINE_TABLE_DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [IW-1:0]           addr_a_i,
  input  logic [IW-1:0]           addr_b_i,
  output logic signed [COS_W-1:0] data_a_o,
  output logic signed [COS_W-1:0] data_b_o
);

  logic signed [COS_W-1:0] rom_w [COSINE_TABLE_DEPTH];

  // Entry k holds cos(2 pi k / depth), phase rounded to 2^-32 turn.
  for (genvar g = 0; g < COSINE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned GL    = g;
    localparam longint unsigned PHASE =
      ((GL << 33) + COSINE_TABLE_DEPTH) / (2 * COSINE_TABLE_DEPTH);
    assign rom_w[g] = cos_q30(PHASE[31:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= rom_w[addr_a_i];
      data_b_o <= rom_w[addr_b_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/aww_back.sv */
`default_nettype none

module aww_back import aww_pkg::*; #(
  parameter int COSINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  aww_item_t   head_i,
  input  logic        empty_i,
  output logic        pop_o,
  aww_weight_if.source weight_o
);

  localparam int IW = $clog2(COSINE_TABLE_DEPTH);
  localparam int QW = IW + 1;

  logic                   en;
  logic [QW:0]            vld_q;
  aww_item_t              item_q [QW+1];
  logic [DIVIDEND_W-1:0]  rem_q  [QW+1];
  logic [QW-1:0]          quo_q  [QW+1];
  logic [DIVIDEND_W-1:0]  trial_w [QW];
  logic                   fits_w  [QW];

  logic [QW-1:0]          k1_full;
  logic [IW-1:0]          k1;
  logic signed [COS_W-1:0] c1, c2;
  logic                   vld_r_q, vld_c_q, vld_m_q, out_vld_q;
  aww_item_t              item_r_q, item_c_q, item_m_q;

  logic signed [COEF_W-1:0] coef_a, coef_b, coef_e;
  logic signed [ACC_W-1:0]  v_d, v_q;
  logic signed [ACC_W-1:0]  v_round;
  logic [QUOT_W-1:0]        y;
  logic [PROD_W-1:0]        prod_q;
  logic                     pos_q;
  logic [SCALED_W-1:0]      scaled;
  logic [WEIGHT_W-1:0]      weight_d, weight_q;

  // Whole back pipeline advances together when the output slot frees.
  assign en    = !out_vld_q || weight_o.ready;
  assign pop_o = en;

  // Restoring divider, one quotient bit per stage.
  always_comb begin
    for (int i = 0; i < QW; i++) begin
      trial_w[i] = DIVIDEND_W'(item_q[i].divisor) << (QW - 1 - i);
      fits_w[i]  = rem_q[i] >= trial_w[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= head_i.dividend;
      quo_q[0]  <= '0;
      item_q[0] <= head_i;
      for (int i = 0; i < QW; i++) begin
        rem_q[i+1]  <= fits_w[i] ? rem_q[i] - trial_w[i] : rem_q[i];
        quo_q[i+1]  <= quo_q[i] | (fits_w[i] ? (QW'(1) << (QW - 1 - i)) : '0);
        item_q[i+1] <= item_q[i];
      end
    end
  end

  assign k1_full = (quo_q[QW] >= QW'(COSINE_TABLE_DEPTH))
                 ? quo_q[QW] - QW'(COSINE_TABLE_DEPTH) : quo_q[QW];
  assign k1 = k1_full[IW-1:0];

  aww_cos_rom #(
    .COSINE_TABLE_DEPTH(COSINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i    (clk_i),
    .en_i     (en),
    .addr_a_i (k1),
    .addr_b_i (item_q[QW].k2[IW-1:0]),
    .data_a_o (c1),
    .data_b_o (c2)
  );

  // 100 * weight in Q30 from the window coefficients.
  always_comb begin
    case (item_r_q.kind)
      KIND_HANN:     begin coef_a = 8'sd50; coef_b = 8'sd50; coef_e = 8'sd0; end
      KIND_HAMMING:  begin coef_a = 8'sd54; coef_b = 8'sd46; coef_e = 8'sd0; end
      KIND_BLACKMAN: begin coef_a = 8'sd42; coef_b = 8'sd50; coef_e = 8'sd8; end
      KIND_TAPER:    begin coef_a = 8'sd50; coef_b = 8'sd50; coef_e = 8'sd0; end
      default:       begin coef_a = 8'sd0;  coef_b = 8'sd0;  coef_e = 8'sd0; end
    endcase
    v_d = (ACC_W'(coef_a) <<< 30)
        - ACC_W'(coef_b) * ACC_W'(c1)
        + ACC_W'(coef_e) * ACC_W'(c2);
  end

  // Divide by 100 * 2^15: shift, then reciprocal multiply (exact in range).
  assign v_round = (v_q + ROUND_HALF) >>> FRAC_SHIFT;
  assign y       = v_round[QUOT_W-1:0];
  assign scaled  = prod_q[PROD_W-1:RECIP_SHIFT];

  always_comb begin
    if (item_m_q.kind == KIND_DIRECT) begin
      weight_d = item_m_q.direct_weight;
    end else if (!pos_q) begin
      weight_d = '0;
    end else if (scaled > SCALED_W'(WEIGHT_ONE)) begin
      weight_d = WEIGHT_ONE;
    end else begin
      weight_d = scaled[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_r_q <= item_q[QW];
      item_c_q <= item_r_q;
      v_q      <= v_d;
      item_m_q <= item_c_q;
      pos_q    <= v_q > 0;
      prod_q   <= PROD_W'(y) * PROD_W'(RECIP_100);
      weight_q <= weight_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_r_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_m_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[QW-1:0], !empty_i};
      vld_r_q   <= vld_q[QW];
      vld_c_q   <= vld_r_q;
      vld_m_q   <= vld_c_q;
      out_vld_q <= vld_m_q;
    end
  end

  assign weight_o.valid  = out_vld_q;
  assign weight_o.weight = weight_q;

endmodule

`default_nettype wire
